[rtl/bzs_pkg.sv]
// ============================================================================
// bzs_pkg
// Shared types and default constants for the cubic Bezier spline evaluator.
// ============================================================================
package bzs_pkg;

    localparam int MAX_SEGMENTS_DEF    = 16;
    localparam int COORD_BITS_DEF      = 32;
    localparam int PARAM_FRAC_BITS_DEF = 16;

    localparam int CURVE_COUNT_W = 5;
    localparam int SEG_INDEX_W   = 4;
    localparam int POINT_W       = 2;
    localparam int REQ_W         = 2;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD    = 2'd0,
        REQ_POINT   = 2'd1,
        REQ_TANGENT = 2'd2,
        REQ_NONE    = 2'd3
    } req_t;

endpackage

[rtl/bzs_store.sv]
// ============================================================================
// bzs_store
// Control point memory: one row per segment, four points per row, one lane
// per point written on a load, whole row read into an output register.
// ============================================================================
module bzs_store #(
    parameter int MAX_SEGMENTS = bzs_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = bzs_pkg::COORD_BITS_DEF,
    parameter int SEG_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [SEG_W-1:0]                   wr_seg,
    input  logic [bzs_pkg::POINT_W-1:0]        wr_pt,
    input  logic [COORD_BITS-1:0]              wr_x,
    input  logic [COORD_BITS-1:0]              wr_y,
    input  logic [COORD_BITS-1:0]              wr_z,
    input  logic                               rd_en,
    input  logic [SEG_W-1:0]                   rd_seg,
    output logic [3:0][COORD_BITS-1:0]         rd_x,
    output logic [3:0][COORD_BITS-1:0]         rd_y,
    output logic [3:0][COORD_BITS-1:0]         rd_z
);

    logic [3:0][COORD_BITS-1:0] mem_x [MAX_SEGMENTS];
    logic [3:0][COORD_BITS-1:0] mem_y [MAX_SEGMENTS];
    logic [3:0][COORD_BITS-1:0] mem_z [MAX_SEGMENTS];
    logic [3:0]                 vld_reg [MAX_SEGMENTS];

    logic [3:0][COORD_BITS-1:0] rdx_reg, rdy_reg, rdz_reg;
    logic [3:0]                 rdv_reg;

    // Write one point lane, read a whole row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_seg][wr_pt] <= wr_x;
            mem_y[wr_seg][wr_pt] <= wr_y;
            mem_z[wr_seg][wr_pt] <= wr_z;
        end
        if (rd_en)
        begin
            rdx_reg <= mem_x[rd_seg];
            rdy_reg <= mem_y[rd_seg];
            rdz_reg <= mem_z[rd_seg];
        end
    end

    // Track written points; unwritten points read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SEGMENTS; i++)
            begin
                vld_reg[i] <= '0;
            end
            rdv_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_seg][wr_pt] <= 1'b1;
            end
            if (rd_en)
            begin
                rdv_reg <= vld_reg[rd_seg];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            rd_x[k] = rdv_reg[k] ? rdx_reg[k] : '0;
            rd_y[k] = rdv_reg[k] ? rdy_reg[k] : '0;
            rd_z[k] = rdv_reg[k] ? rdz_reg[k] : '0;
        end
    end

endmodule

[rtl/bzs_axis.sv]
// ============================================================================
// bzs_axis
// One coordinate axis: three pipelined levels of de Casteljau blends, then
// tangent scaling and saturation into the output register.
// ============================================================================
module bzs_axis #(
    parameter int COORD_BITS      = bzs_pkg::COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = bzs_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [3:0][COORD_BITS-1:0]    ctrl,
    input  logic [PARAM_FRAC_BITS:0]      t_in,
    input  logic                          tan_in,
    output logic [COORD_BITS-1:0]         result
);

    localparam int W = COORD_BITS + 2;
    localparam int F = PARAM_FRAC_BITS;
    localparam int PW = W + F + 3;
    localparam logic signed [PW-1:0] HALF = {{(W+3){1'b0}}, 1'b1, {(F-1){1'b0}}};
    localparam logic signed [W+1:0] SAT_HI = {{(W+3-COORD_BITS){1'b0}}, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [W+1:0] SAT_LO = ~SAT_HI;

    // a + round((b - a) * t), halves toward plus infinity
    function automatic logic signed [W-1:0] blend(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b,
                                                  input logic [F:0] t);
        logic signed [W:0]    d;
        logic signed [PW-1:0] pr;
        logic signed [PW-1:0] sh;
        d  = {b[W-1], b} - {a[W-1], a};
        pr = d * $signed({1'b0, t});
        sh = (pr + HALF) >>> F;
        return a + sh[W-1:0];
    endfunction

    logic signed [W-1:0] p [4];
    logic signed [W-1:0] dd [3];
    logic signed [W-1:0] l1_next [3];
    logic signed [W-1:0] l1_reg [3];
    logic signed [W-1:0] l2_reg [2];
    logic signed [W-1:0] l3_reg;
    logic [F:0]          t2_reg, t3_reg;
    logic                tan2_reg, tan3_reg, tan4_reg;
    logic signed [W+1:0] scaled;
    logic [COORD_BITS-1:0] result_reg, result_next;

    // Widen control points and form differences for the tangent
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            p[k] = W'($signed(ctrl[k]));
        end
        for (int k = 0; k < 3; k++)
        begin
            dd[k] = p[k+1] - p[k];
        end
        if (tan_in)
        begin
            l1_next[0] = blend(dd[0], dd[1], t_in);
            l1_next[1] = blend(dd[1], dd[2], t_in);
            l1_next[2] = '0;
        end
        else
        begin
            l1_next[0] = blend(p[0], p[1], t_in);
            l1_next[1] = blend(p[1], p[2], t_in);
            l1_next[2] = blend(p[2], p[3], t_in);
        end
    end

    // Scale tangent by three and saturate
    always_comb
    begin
        scaled = tan4_reg ? ((W+2)'(l3_reg) <<< 1) + (W+2)'(l3_reg) : (W+2)'(l3_reg);
        if (scaled > SAT_HI)
        begin
            result_next = SAT_HI[COORD_BITS-1:0];
        end
        else if (scaled < SAT_LO)
        begin
            result_next = SAT_LO[COORD_BITS-1:0];
        end
        else
        begin
            result_next = scaled[COORD_BITS-1:0];
        end
    end

    // Advance the blend levels
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1_reg    <= l1_next;
            t2_reg    <= t_in;
            tan2_reg  <= tan_in;
            l2_reg[0] <= blend(l1_reg[0], l1_reg[1], t2_reg);
            l2_reg[1] <= blend(l1_reg[1], l1_reg[2], t2_reg);
            t3_reg    <= t2_reg;
            tan3_reg  <= tan2_reg;
            l3_reg    <= tan3_reg ? l2_reg[0] : blend(l2_reg[0], l2_reg[1], t3_reg);
            tan4_reg  <= tan3_reg;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

[rtl/cubic_bezier_spline_evaluator.sv]
// ============================================================================
// cubic_bezier_spline_evaluator
// Piecewise cubic Bezier spline: control point store and point/tangent
// evaluation pipeline.
// ============================================================================
// Usage:
//   Requests arrive on req_valid/req_ready. A load request writes one control
//   point and returns nothing; an evaluate request (point or tangent) returns
//   one result on result_valid/result_ready. Request code 3 is dropped.
//   The user must write curve_count through cfg_wen/cfg_wdata only while the
//   block is idle; the block itself does not enforce this. An evaluate request
//   passes through the row read, three blend levels and the output register.
//   Throughput: one request per cycle; the pipeline is a single stall domain
//   held only when the output register is full and not taken.
//   Reset clears curve_count, the pipeline valid bits and the per-point valid
//   bits of the store, so every control point reads as zero until loaded.
//   When the receiver stalls with a result waiting, req_ready drops and all stages hold.
//   With zero active segments a result carries zero coordinates and
//   no_segments set.
// ============================================================================
module cubic_bezier_spline_evaluator #(
    parameter int MAX_SEGMENTS    = bzs_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_BITS      = bzs_pkg::COORD_BITS_DEF,
    parameter int PARAM_FRAC_BITS = bzs_pkg::PARAM_FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wen,
    input  logic [bzs_pkg::CURVE_COUNT_W-1:0]       cfg_wdata,
    input  logic                                    req_valid,
    output logic                                    req_ready,
    input  logic [bzs_pkg::REQ_W-1:0]               req_type,
    input  logic [bzs_pkg::SEG_INDEX_W-1:0]         segment_index,
    input  logic [bzs_pkg::POINT_W-1:0]             point_index,
    input  logic signed [COORD_BITS-1:0]            load_x,
    input  logic signed [COORD_BITS-1:0]            load_y,
    input  logic signed [COORD_BITS-1:0]            load_z,
    input  logic signed [PARAM_FRAC_BITS+1:0]       position,
    output logic                                    result_valid,
    input  logic                                    result_ready,
    output logic signed [COORD_BITS-1:0]            result_x,
    output logic signed [COORD_BITS-1:0]            result_y,
    output logic signed [COORD_BITS-1:0]            result_z,
    output logic                                    no_segments
);

    localparam int F     = PARAM_FRAC_BITS;
    localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int N_W   = $clog2(MAX_SEGMENTS + 1);
    localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

    logic [bzs_pkg::CURVE_COUNT_W-1:0] curve_count_reg;
    logic adv, acc, load_acc, eval_acc, tan_req;
    logic [F:0]       pclamp, t_sel;
    logic [N_W-1:0]   n_eff;
    logic [F+N_W:0]   u;
    logic [N_W:0]     idx;
    logic [SEG_W-1:0] rd_seg;
    logic             wr_en;

    logic [4:0] vld_reg;
    logic [4:0] nos_reg;
    logic [F:0] t1_reg;
    logic       tan1_reg;

    logic [3:0][COORD_BITS-1:0] row_x, row_y, row_z;
    logic [3:0][COORD_BITS-1:0] ax_x, ax_y, ax_z;

    // Handshake
    assign adv       = !vld_reg[4] || result_ready;
    assign req_ready = adv;
    assign acc       = req_valid && adv;
    assign load_acc  = acc && (req_type == bzs_pkg::REQ_LOAD);
    assign tan_req   = (req_type == bzs_pkg::REQ_TANGENT);
    assign eval_acc  = acc && ((req_type == bzs_pkg::REQ_POINT) || tan_req);
    assign wr_en     = load_acc && (32'(segment_index) < MAX_SEGMENTS);

    // Clamp position, scale by segment count, split into segment and t
    always_comb
    begin
        if (position[F+1])
        begin
            pclamp = '0;
        end
        else if (position[F:0] > T_ONE)
        begin
            pclamp = T_ONE;
        end
        else
        begin
            pclamp = position[F:0];
        end
        n_eff = (32'(curve_count_reg) > MAX_SEGMENTS) ? N_W'(MAX_SEGMENTS)
                                                      : N_W'(curve_count_reg);
        u     = pclamp * n_eff;
        idx   = u[F+N_W:F];
        if (idx >= {1'b0, n_eff})
        begin
            rd_seg = SEG_W'(n_eff - N_W'(1));
            t_sel  = T_ONE;
        end
        else
        begin
            rd_seg = idx[SEG_W-1:0];
            t_sel  = {1'b0, u[F-1:0]};
        end
    end

    // Config register and pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_count_reg <= '0;
            vld_reg         <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                curve_count_reg <= cfg_wdata;
            end
            if (adv)
            begin
                vld_reg <= {vld_reg[3:0], eval_acc};
            end
        end
    end

    // Carry request attributes alongside the row read
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg   <= t_sel;
            tan1_reg <= tan_req;
            nos_reg  <= {nos_reg[3:0], (n_eff == '0)};
        end
    end

    bzs_store #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS),
        .SEG_W        (SEG_W)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_seg (SEG_W'(segment_index)),
        .wr_pt  (point_index),
        .wr_x   (load_x),
        .wr_y   (load_y),
        .wr_z   (load_z),
        .rd_en  (adv),
        .rd_seg (rd_seg),
        .rd_x   (row_x),
        .rd_y   (row_y),
        .rd_z   (row_z)
    );

    // Zero the control points when no segment is active
    assign ax_x = nos_reg[0] ? '0 : row_x;
    assign ax_y = nos_reg[0] ? '0 : row_y;
    assign ax_z = nos_reg[0] ? '0 : row_z;

    bzs_axis #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_axis_x (
        .clk(clk), .adv(adv), .ctrl(ax_x), .t_in(t1_reg), .tan_in(tan1_reg),
        .result(result_x)
    );

    bzs_axis #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_axis_y (
        .clk(clk), .adv(adv), .ctrl(ax_y), .t_in(t1_reg), .tan_in(tan1_reg),
        .result(result_y)
    );

    bzs_axis #(.COORD_BITS(COORD_BITS), .PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_axis_z (
        .clk(clk), .adv(adv), .ctrl(ax_z), .t_in(t1_reg), .tan_in(tan1_reg),
        .result(result_z)
    );

    assign result_valid = vld_reg[4];
    assign no_segments  = nos_reg[4];

endmodule

[sim/cubic_bezier_spline_evaluator_tb.sv]
// ============================================================================
// cubic_bezier_spline_evaluator_tb
// Self-checking testbench for the cubic Bezier spline evaluator. A directed
// table covers the empty spline, clamping, the spline end, saturating control
// points and count limits. Random phases with different curve counts follow.
// A behavioral predictor supplies the expected point or tangent for each
// evaluate request with no fixed table result; every result is checked in order.
// ============================================================================
module cubic_bezier_spline_evaluator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int        SEGS      = 16;
    localparam int        DEPTH     = SEGS * 4;
    localparam longint    T_ONE     = 65536;
    localparam int        LIMIT     = 400000;
    localparam logic [17:0] POS_ONE = 18'h10000;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               ns;
    } spline_result_t;

    typedef struct packed {
        bit                 is_cfg;
        logic [4:0]         cfg;
        bzs_pkg::req_t      req;
        logic [3:0]         seg;
        logic [1:0]         pt;
        logic [31:0]        x;
        logic [31:0]        y;
        logic [31:0]        z;
        logic [17:0]        pos;
        bit                 fixed;
        spline_result_t     res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [4:0]  cfg_wdata;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  req_type;
    logic [3:0]  segment_index;
    logic [1:0]  point_index;
    logic signed [31:0] load_x, load_y, load_z;
    logic signed [17:0] position;
    logic        result_valid;
    logic        result_ready;
    logic signed [31:0] result_x, result_y, result_z;
    logic        no_segments;

    // predictor state
    logic signed [31:0] ctl_x [DEPTH];
    logic signed [31:0] ctl_y [DEPTH];
    logic signed [31:0] ctl_z [DEPTH];
    logic [4:0]         active_count;

    spline_result_t pending_results [$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  calm;
    bit  long_stall;

    cubic_bezier_spline_evaluator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req_type      (req_type),
        .segment_index (segment_index),
        .point_index   (point_index),
        .load_x        (load_x),
        .load_y        (load_y),
        .load_z        (load_z),
        .position      (position),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_x      (result_x),
        .result_y      (result_y),
        .result_z      (result_z),
        .no_segments   (no_segments)
    );

    // Directed requests: empty spline, extremes, clamping, end of spline, limits
    stim_row_t directed_rows [] = '{
        '{0, 0, bzs_pkg::REQ_POINT,   0, 0, 0, 0, 0, 18'h00000, 1, '{0, 0, 0, 1}},
        '{0, 0, bzs_pkg::REQ_TANGENT, 0, 0, 0, 0, 0, POS_ONE,   1, '{0, 0, 0, 1}},
        '{0, 0, bzs_pkg::REQ_NONE,    0, 0, 0, 0, 0, 18'h00000, 0, '{0, 0, 0, 0}},
        '{1, 1, bzs_pkg::REQ_NONE,    0, 0, 0, 0, 0, 18'h00000, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_POINT,   0, 0, 0, 0, 0, 18'h08000, 1, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_LOAD,    0, 0, 32'h80000000, 32'h7fffffff, 32'h00010000,
          18'h00000, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_LOAD,    0, 1, 32'h7fffffff, 32'h80000000, 32'hfffe0000,
          18'h00000, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_LOAD,    0, 2, 32'h80000000, 32'h7fffffff, 32'h00030000,
          18'h00000, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_LOAD,    0, 3, 32'h7fffffff, 32'h80000000, 32'hfffc0000,
          18'h00000, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_POINT,   0, 0, 0, 0, 0, 18'h00000, 1,
          '{32'h80000000, 32'h7fffffff, 32'h00010000, 0}},
        '{0, 0, bzs_pkg::REQ_TANGENT, 0, 0, 0, 0, 0, POS_ONE,   0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_POINT,   0, 0, 0, 0, 0, 18'h20000, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_POINT,   0, 0, 0, 0, 0, 18'h1ffff, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_TANGENT, 0, 0, 0, 0, 0, 18'h08000, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_TANGENT, 0, 0, 0, 0, 0, 18'h3ffff, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_LOAD,   15, 0, 32'h00001234, 32'hffff0000, 32'h00000001,
          18'h00000, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_LOAD,   15, 3, 32'h7fffffff, 32'h00050000, 32'h80000000,
          18'h00000, 0, '{0, 0, 0, 0}},
        '{1, 16, bzs_pkg::REQ_NONE,   0, 0, 0, 0, 0, 18'h00000, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_POINT,   0, 0, 0, 0, 0, POS_ONE,   0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_TANGENT, 0, 0, 0, 0, 0, 18'h0ffff, 0, '{0, 0, 0, 0}},
        '{1, 31, bzs_pkg::REQ_NONE,   0, 0, 0, 0, 0, 18'h00000, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_POINT,   0, 0, 0, 0, 0, POS_ONE,   0, '{0, 0, 0, 0}},
        '{1, 0, bzs_pkg::REQ_NONE,    0, 0, 0, 0, 0, 18'h00000, 0, '{0, 0, 0, 0}},
        '{0, 0, bzs_pkg::REQ_TANGENT, 0, 0, 0, 0, 0, 18'h04000, 1, '{0, 0, 0, 1}}
    };

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // a + round((b - a) * t / 2^16), halves upward
    function automatic longint lerp_q16(longint a, longint b, longint t);
        return a + (((b - a) * t + 32768) >>> 16);
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] axis_value(longint p0, longint p1,
                                                      longint p2, longint p3,
                                                      longint t, bit tangent);
        longint a, b, c, d, e;
        if (tangent)
        begin
            a = lerp_q16(p1 - p0, p2 - p1, t);
            b = lerp_q16(p2 - p1, p3 - p2, t);
            return clip32(3 * lerp_q16(a, b, t));
        end
        a = lerp_q16(p0, p1, t);
        b = lerp_q16(p1, p2, t);
        c = lerp_q16(p2, p3, t);
        d = lerp_q16(a, b, t);
        e = lerp_q16(b, c, t);
        return clip32(lerp_q16(d, e, t));
    endfunction

    function automatic spline_result_t eval_spline(logic signed [17:0] pos, bit tangent);
        spline_result_t r;
        longint n, p, u, idx, t;
        int base;
        n = (active_count > SEGS) ? SEGS : active_count;
        r = '0;
        if (n == 0)
        begin
            r.ns = 1'b1;
            return r;
        end
        // clamp to [0, 1.0]
        p = (pos < 0) ? 0 : ((pos > T_ONE) ? T_ONE : longint'(pos));
        u = p * n;
        idx = u >> 16;
        t = u & (T_ONE - 1);
        // spline end: last segment at t = 1
        if (idx >= n)
        begin
            idx = n - 1;
            t = T_ONE;
        end
        base = int'(idx) * 4;
        r.x = axis_value(ctl_x[base], ctl_x[base+1], ctl_x[base+2], ctl_x[base+3],
                         t, tangent);
        r.y = axis_value(ctl_y[base], ctl_y[base+1], ctl_y[base+2], ctl_y[base+3],
                         t, tangent);
        r.z = axis_value(ctl_z[base], ctl_z[base+1], ctl_z[base+2], ctl_z[base+3],
                         t, tangent);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Drive one request from a falling edge, hold until accepted, end at a falling edge
    task automatic send_request(stim_row_t r);
        spline_result_t expected;
        req_valid     = 1'b1;
        req_type      = r.req;
        segment_index = r.seg;
        point_index   = r.pt;
        load_x        = r.x;
        load_y        = r.y;
        load_z        = r.z;
        position      = r.pos;
        do
            @(posedge clk);
        while (!req_ready);
        // advance the predictor in acceptance order
        if (r.req == bzs_pkg::REQ_LOAD)
        begin
            ctl_x[r.seg * 4 + r.pt] = r.x;
            ctl_y[r.seg * 4 + r.pt] = r.y;
            ctl_z[r.seg * 4 + r.pt] = r.z;
        end
        else if (r.req != bzs_pkg::REQ_NONE)
        begin
            expected = r.fixed ? r.res
                               : eval_spline(r.pos, r.req == bzs_pkg::REQ_TANGENT);
            pending_results.insert(pending_results.size(), expected);
        end
        @(negedge clk);
    endtask

    task automatic drop_valid();
        req_valid = 1'b0;
    endtask

    // Write curve_count once the block has drained
    task automatic write_count(logic [4:0] value);
        drop_valid();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_wen   = 1'b0;
        active_count = value;
    endtask

    function automatic stim_row_t random_request(int load_pct);
        stim_row_t r;
        int pick;
        r = '0;
        pick = $urandom_range(0, 99);
        if (pick < load_pct)
            r.req = bzs_pkg::REQ_LOAD;
        else if (pick < 97)
            r.req = ($urandom_range(0, 1) != 0) ? bzs_pkg::REQ_POINT : bzs_pkg::REQ_TANGENT;
        else
            r.req = bzs_pkg::REQ_NONE;
        r.seg = 4'($urandom_range(0, 15));
        r.pt  = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1) != 0)
        begin
            r.x = $urandom;
            r.y = $urandom;
            r.z = $urandom;
        end
        else
        begin
            // moderate values so most results stay unsaturated
            r.x = $urandom_range(0, 32'h01ffffff) - 32'h01000000;
            r.y = $urandom_range(0, 32'h01ffffff) - 32'h01000000;
            r.z = $urandom_range(0, 32'h01ffffff) - 32'h01000000;
        end
        case ($urandom_range(0, 9))
            0: r.pos = 18'($urandom);
            1: r.pos = 18'h20000 | 18'($urandom_range(0, 18'h1ffff));
            2: r.pos = 18'h00000;
            3: r.pos = POS_ONE;
            4: r.pos = 18'h10001 + 18'($urandom_range(0, 18'h0fffe));
            default: r.pos = 18'($urandom_range(0, 65536));
        endcase
        return r;
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        spline_result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no request outstanding", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_x !== want.x)
                    report_mismatch("result_x", result_x, want.x);
                if (result_y !== want.y)
                    report_mismatch("result_y", result_y, want.y);
                if (result_z !== want.z)
                    report_mismatch("result_z", result_z, want.z);
                if (no_segments !== want.ns)
                    report_mismatch("no_segments", no_segments, want.ns);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("cubic_bezier_spline_evaluator: mismatch");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_stall)
            begin
                result_ready = 1'b0;
                repeat (60) @(negedge clk);
                long_stall = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                result_ready = 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            else
            begin
                result_ready = 1'b1;
            end
        end
    end

    // Sender
    initial
    begin
        logic [4:0] count_choices [9] = '{0, 1, 2, 3, 5, 15, 16, 17, 31};
        stim_row_t r;
        int phase;
        calm          = 1'b0;
        long_stall    = 1'b0;
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = '0;
        req_valid     = 1'b0;
        req_type      = bzs_pkg::REQ_NONE;
        segment_index = '0;
        point_index   = '0;
        load_x        = '0;
        load_y        = '0;
        load_z        = '0;
        position      = '0;
        active_count  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            ctl_x[i] = '0;
            ctl_y[i] = '0;
            ctl_z[i] = '0;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // walk the directed table
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_count(directed_rows[i].cfg);
            else
                send_request(directed_rows[i]);
        end

        // random phases, each with its own curve count
        for (phase = 0; phase < 11; phase++)
        begin
            write_count((phase < 9) ? count_choices[phase] : 5'($urandom_range(0, 31)));
            calm = (phase == 10);
            // fill the spline first so evaluations see real segments
            for (int s = 0; s < 4; s++)
            begin
                r = random_request(100);
                r.seg = (phase == 0) ? 4'(s) : 4'($urandom_range(0, 4));
                send_request(r);
            end
            if (phase == 6)
            begin
                // hold the receiver off while evaluations pile up
                long_stall = 1'b1;
                repeat (30) send_request(random_request(0));
            end
            for (int k = 0; k < 43; k++)
            begin
                if (!calm && $urandom_range(0, 3) == 0)
                begin
                    drop_valid();
                    repeat ($urandom_range(1, 6)) @(negedge clk);
                end
                send_request(random_request(30));
            end
            if (phase == 3)
            begin
                // pause until the block has drained
                drop_valid();
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
        end
        drop_valid();

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("cubic_bezier_spline_evaluator: match");
        else
            $display("cubic_bezier_spline_evaluator: mismatch");
        $finish;
    end

endmodule
